// ----- rtl/core/mrr_pkg.sv -----
`default_nettype none

package mrr_pkg;

  // Field widths of the stream beats.
  localparam int unsigned CAND_FIELD_BITS = 32;
  localparam int unsigned DRAW_BITS       = 64;
  localparam int unsigned S_TDATA_BITS    = CAND_FIELD_BITS + DRAW_BITS;
  localparam int unsigned M_TDATA_BITS    = 8;

  // The shared remainder unit always walks the full 64-bit dividend.
  localparam int unsigned RED_CNT_BITS = $clog2(DRAW_BITS);

endpackage : mrr_pkg

`default_nettype wire

// ----- rtl/core/miller_rabin_round_core.sv -----
`default_nettype none

// One round of the Miller-Rabin primality test.
//
// Input channel (s_t*): one beat carries a candidate and a raw 64-bit random
// draw. Only the low CAND_BITS bits of the candidate are used. Output channel
// (m_t*): one beat per input beat, bit 0 is 1 when the round passes or the
// candidate is 2 or 3, and 0 when the candidate is found composite.
//
// The block works on one candidate at a time and keeps s_tready low from the
// accepting edge until its result beat has been taken. For candidates 0 to 4,
// m_tvalid rises at the accepting edge itself. Any other candidate runs through
// one shared restoring remainder unit that retires one dividend bit per cycle:
// one reduction picks the witness, each modular multiplication takes one
// multiply step (S_MUL) plus one reduction (S_RED), and each exponent bit adds
// one sequencing step (S_POW). After the exponent, at most s-1 squarings follow,
// with s the power of two in n-1. Reset returns the sequencer to idle and drops
// m_tvalid. When the receiver stalls, the verdict holds on m_tdata and no new
// beat is accepted.
module miller_rabin_round_core #(
  parameter int unsigned CAND_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata, from bit 0 up: candidate[31:0], random_draw[63:0].
  input  wire logic [mrr_pkg::S_TDATA_BITS-1:0]  s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata, from bit 0 up: probably_prime, then seven zero bits.
  output logic [mrr_pkg::M_TDATA_BITS-1:0]       m_tdata
);

  import mrr_pkg::*;

  localparam int unsigned N  = CAND_BITS;
  localparam int unsigned SW = $clog2(CAND_BITS);
  localparam logic [RED_CNT_BITS-1:0] RED_LAST = RED_CNT_BITS'(DRAW_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIT,
    S_STRIP,
    S_POW,
    S_MUL,
    S_RED,
    S_DONE
  } state_t;

  // Which value a running modular multiplication updates.
  typedef enum logic [1:0] {
    OP_ACC,
    OP_BASE,
    OP_SQR
  } op_t;

  state_t                  state;
  op_t                     op;
  logic                    verdict;
  logic [N-1:0]            n_val;
  logic [N-1:0]            nm1;
  logic [N-1:0]            modulus;
  logic [DRAW_BITS-1:0]    dividend;
  logic [N-1:0]            rem;
  logic [RED_CNT_BITS-1:0] cnt;
  logic [N-1:0]            acc;
  logic [N-1:0]            base_val;
  logic [N-1:0]            d_val;
  logic [SW-1:0]           s_cnt;
  logic [SW-1:0]           sq_left;

  logic [N-1:0]   cand;
  logic [N:0]     trial;
  logic           trial_ge;
  logic [N-1:0]   rem_next;
  logic [N-1:0]   mul_a;
  logic [N-1:0]   mul_b;
  logic [2*N-1:0] product;

  assign cand = s_tdata[N-1:0];

  // Shared restoring remainder step: shift in one dividend bit, subtract the
  // modulus when it fits.
  assign trial    = {rem, dividend[DRAW_BITS-1]};
  assign trial_ge = trial >= {1'b0, modulus};
  assign rem_next = trial_ge ? N'(trial - {1'b0, modulus}) : trial[N-1:0];

  always_comb begin
    unique case (op)
      OP_ACC: begin
        mul_a = acc;
        mul_b = base_val;
      end
      OP_BASE: begin
        mul_a = base_val;
        mul_b = base_val;
      end
      default: begin
        mul_a = acc;
        mul_b = acc;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_DONE);
  assign m_tdata  = {{(M_TDATA_BITS-1){1'b0}}, verdict};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n_val    <= cand;
            nm1      <= cand - N'(1);
            modulus  <= cand - N'(4);
            dividend <= s_tdata[S_TDATA_BITS-1:CAND_FIELD_BITS];
            rem      <= '0;
            cnt      <= '0;
            d_val    <= cand - N'(1);
            s_cnt    <= '0;
            if (cand <= N'(1) || cand == N'(4)) begin
              verdict <= 1'b0;
              state   <= S_DONE;
            end else if (cand <= N'(3)) begin
              verdict <= 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_WIT;
            end
          end
        end

        // Witness a = 2 + draw mod (n-4); it stays below n, so it is already
        // the reduced base.
        S_WIT: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          cnt      <= cnt + 1'b1;
          if (cnt == RED_LAST) begin
            base_val <= N'(rem_next + N'(2));
            modulus  <= n_val;
            state    <= S_STRIP;
          end
        end

        // Strip factors of two from n-1; d never reaches zero since n > 4.
        S_STRIP: begin
          if (!d_val[0]) begin
            d_val <= d_val >> 1;
            s_cnt <= s_cnt + 1'b1;
          end else begin
            acc   <= N'(1);
            state <= S_POW;
          end
        end

        // Square-and-multiply, least significant exponent bit first. When the
        // exponent is used up, acc holds x = a^d mod n.
        S_POW: begin
          if (d_val == '0) begin
            if (acc == N'(1) || acc == nm1) begin
              verdict <= 1'b1;
              state   <= S_DONE;
            end else if (s_cnt <= SW'(1)) begin
              verdict <= 1'b0;
              state   <= S_DONE;
            end else begin
              sq_left <= s_cnt - SW'(1);
              op      <= OP_SQR;
              state   <= S_MUL;
            end
          end else begin
            op    <= d_val[0] ? OP_ACC : OP_BASE;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          dividend <= DRAW_BITS'(product);
          rem      <= '0;
          cnt      <= '0;
          state    <= S_RED;
        end

        S_RED: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          cnt      <= cnt + 1'b1;
          if (cnt == RED_LAST) begin
            unique case (op)
              OP_ACC: begin
                acc   <= rem_next;
                op    <= OP_BASE;
                state <= S_MUL;
              end
              OP_BASE: begin
                base_val <= rem_next;
                d_val    <= d_val >> 1;
                state    <= S_POW;
              end
              default: begin
                acc <= rem_next;
                if (rem_next == N'(1)) begin
                  verdict <= 1'b0;
                  state   <= S_DONE;
                end else if (rem_next == nm1) begin
                  verdict <= 1'b1;
                  state   <= S_DONE;
                end else if (sq_left == SW'(1)) begin
                  verdict <= 1'b0;
                  state   <= S_DONE;
                end else begin
                  sq_left <= sq_left - SW'(1);
                  state   <= S_MUL;
                end
              end
            endcase
          end
        end

        S_DONE: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : miller_rabin_round_core

`default_nettype wire

// ----- rtl/core/mrr_checker.sv -----
`default_nettype none

module mrr_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [mrr_pkg::S_TDATA_BITS-1:0]  s_tdata,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [mrr_pkg::M_TDATA_BITS-1:0]  m_tdata
);

  import mrr_pkg::*;

  // The core holds one item at a time: never ready while a verdict waits.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while a result beat is pending");

  // Once an item is taken the core is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still ready right after an accepted beat");

  // After the verdict is delivered the core is idle and empty again.
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
    else $error("core not idle after result beat");

  // A stalled verdict holds.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // Only bit 0 of a result beat carries information.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_BITS-1:1] == '0))
    else $error("padding bits of result beat not zero");

endmodule : mrr_checker

bind miller_rabin_round_core mrr_checker u_mrr_checker (.*);

`default_nettype wire
